[sv/min_cut_edge_finder_core_assert.svh]
`ifndef MIN_CUT_EDGE_FINDER_CORE_ASSERT_SVH
`define MIN_CUT_EDGE_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and silenced during reset.
`define MCEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mcef_pkg.sv]
package mcef_pkg;

    localparam int DEF_MAX_NODES = 16;
    localparam int DEF_MAX_MULT  = 15;
    localparam int CFG_W         = 5;
    localparam int NODE_W        = 5;
    localparam int FLOW_W        = 8;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int REG_NODE_COUNT = 0;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_SOLVE,
        MODE_READ,
        MODE_CLEAR
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ACK,
        KIND_FLOW,
        KIND_CUT,
        KIND_NONE
    } kind_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLR,
        ST_ADD_RD,
        ST_ADD_AB,
        ST_ADD_BA,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_RD,
        ST_BFS_CHK,
        ST_BFS_END,
        ST_AUG_RD,
        ST_AUG_FWD,
        ST_AUG_REV,
        ST_RD_CHK,
        ST_RD_WAIT,
        ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLR,
        OP_REFUSE,
        OP_ADD_RD,
        OP_ADD_AB,
        OP_ADD_BA,
        OP_BFS_INIT,
        OP_BFS_POP,
        OP_BFS_RD,
        OP_BFS_CHK,
        OP_AUG_START,
        OP_AUG_RD,
        OP_AUG_FWD,
        OP_AUG_REV,
        OP_FINISH,
        OP_RD_START,
        OP_RD_ISSUE,
        OP_RD_ADV,
        OP_RD_HIT,
        OP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   take_item;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  item_valid;
        logic  add_bad;
        logic  mult_full;
        logic  v_last;
        logic  q_empty;
        logic  sink_seen;
        logic  pred_is_src;
        logic  clr_last;
        logic  rd_end;
        logic  rd_cand;
        logic  mult_nz;
        logic  out_free;
    } dp_status_t;

endpackage

[sv/mcef_ctrl.sv]
module mcef_ctrl
    import mcef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:     if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:     if (status.item_valid) state_next = ST_DECODE;
            ST_DECODE:
            begin
                case (status.mode)
                    MODE_ADD:   state_next = status.add_bad ? ST_RESP : ST_ADD_RD;
                    MODE_SOLVE: state_next = ST_BFS_INIT;
                    MODE_READ:  state_next = ST_RD_CHK;
                    default:    state_next = ST_CLR;
                endcase
            end
            ST_CLR:      if (status.clr_last) state_next = ST_RESP;
            ST_ADD_RD:   state_next = ST_ADD_AB;
            ST_ADD_AB:   state_next = status.mult_full ? ST_RESP : ST_ADD_BA;
            ST_ADD_BA:   state_next = ST_RESP;
            ST_BFS_INIT: state_next = ST_BFS_POP;
            ST_BFS_POP:  state_next = ST_BFS_RD;
            ST_BFS_RD:   state_next = ST_BFS_CHK;
            ST_BFS_CHK:
            begin
                if (!status.v_last)
                    state_next = ST_BFS_RD;
                else if (status.q_empty)
                    state_next = ST_BFS_END;
                else
                    state_next = ST_BFS_POP;
            end
            ST_BFS_END:  state_next = status.sink_seen ? ST_AUG_RD : ST_RESP;
            ST_AUG_RD:   state_next = ST_AUG_FWD;
            ST_AUG_FWD:  state_next = ST_AUG_REV;
            ST_AUG_REV:  state_next = status.pred_is_src ? ST_BFS_INIT : ST_AUG_RD;
            ST_RD_CHK:
            begin
                if (status.rd_end)
                    state_next = ST_RESP;
                else if (status.rd_cand)
                    state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:  state_next = status.mult_nz ? ST_RESP : ST_RD_CHK;
            ST_RESP:     if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.take_item = 1'b0;
        case (state_reg)
            ST_INIT:     cmd.op = OP_CLR;
            ST_IDLE:
            begin
                cmd.take_item = 1'b1;
                if (status.item_valid) cmd.op = OP_ACCEPT;
            end
            ST_DECODE:
            begin
                if (status.mode == MODE_ADD && status.add_bad)
                    cmd.op = OP_REFUSE;
                else if (status.mode == MODE_READ)
                    cmd.op = OP_RD_START;
            end
            ST_CLR:      cmd.op = OP_CLR;
            ST_ADD_RD:   cmd.op = OP_ADD_RD;
            ST_ADD_AB:   cmd.op = OP_ADD_AB;
            ST_ADD_BA:   cmd.op = OP_ADD_BA;
            ST_BFS_INIT: cmd.op = OP_BFS_INIT;
            ST_BFS_POP:  cmd.op = OP_BFS_POP;
            ST_BFS_RD:   cmd.op = OP_BFS_RD;
            ST_BFS_CHK:  cmd.op = OP_BFS_CHK;
            ST_BFS_END:  cmd.op = status.sink_seen ? OP_AUG_START : OP_FINISH;
            ST_AUG_RD:   cmd.op = OP_AUG_RD;
            ST_AUG_FWD:  cmd.op = OP_AUG_FWD;
            ST_AUG_REV:  cmd.op = OP_AUG_REV;
            ST_RD_CHK:
            begin
                if (!status.rd_end)
                    cmd.op = status.rd_cand ? OP_RD_ISSUE : OP_RD_ADV;
            end
            ST_RD_WAIT:  cmd.op = OP_RD_HIT;
            ST_RESP:     if (status.out_free) cmd.op = OP_RESP;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

[sv/mcef_datapath.sv]
module mcef_datapath
    import mcef_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_MULT  = DEF_MAX_MULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dp_cmd_t                            cmd,
    output dp_status_t                         status,
    input  logic [$clog2(MAX_NODES + 1) - 1:0] n,
    input  logic                               item_valid,
    input  logic [1:0]                         mode,
    input  logic [NODE_W - 1:0]                node_a,
    input  logic [NODE_W - 1:0]                node_b,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [1:0]                         kind,
    output logic [FLOW_W - 1:0]                flow_value,
    output logic [NODE_W - 1:0]                edge_low,
    output logic [NODE_W - 1:0]                edge_high,
    output logic                               ignored
);

    localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int AW = 2 * NB;
    localparam int MW = $clog2(MAX_MULT + 1);
    localparam int RW = MW + 1;
    localparam int DW = MW + RW;
    localparam int DEPTH = 1 << AW;
    localparam logic [NB - 1:0] WALK_LAST = NB'(MAX_NODES - 1);

    // Each cell holds the pair's multiplicity above its residual capacity.
    logic [DW - 1:0] mem [DEPTH];
    logic [DW - 1:0] rdata_reg;
    logic [AW - 1:0] raddr;
    logic [AW - 1:0] waddr;
    logic [DW - 1:0] wdata;
    logic            wen;

    mode_t               mode_reg;
    logic [NODE_W - 1:0] a_reg;
    logic [NODE_W - 1:0] b_reg;
    kind_t               res_kind_reg;
    logic                res_ign_reg;
    logic [NODE_W - 1:0] res_lo_reg;
    logic [NODE_W - 1:0] res_hi_reg;

    logic [AW - 1:0]        clr_idx_reg;
    logic [MAX_NODES - 1:0] visited_reg;
    logic [MAX_NODES - 1:0] reach_reg;
    logic [NB - 1:0]        pred_reg [MAX_NODES];
    logic [NB - 1:0]        queue_reg [MAX_NODES];
    logic [NB:0]            head_reg;
    logic [NB:0]            tail_reg;
    logic [NB - 1:0]        u_reg;
    logic [NB - 1:0]        v_reg;
    logic [NB - 1:0]        w_reg;
    logic [FLOW_W - 1:0]    flow_reg;

    logic [NB - 1:0] cur_i_reg;
    logic [NB - 1:0] cur_j_reg;
    logic            cur_end_reg;
    logic [NB - 1:0] si_reg;
    logic [NB - 1:0] sj_reg;
    logic            send_reg;
    logic [NB - 1:0] si_next;
    logic [NB - 1:0] sj_next;
    logic            send_next;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [FLOW_W - 1:0] out_flow_reg;
    logic [NODE_W - 1:0] out_lo_reg;
    logic [NODE_W - 1:0] out_hi_reg;
    logic                out_ign_reg;

    logic [NB - 1:0] last;
    logic [NB - 1:0] ia;
    logic [NB - 1:0] ib;
    logic [NB - 1:0] pw;
    logic [MW - 1:0] rd_mult;
    logic [RW - 1:0] rd_res;
    logic            mult_full;
    logic            enq_now;
    logic            add_bad;
    logic            out_free;

    assign last     = NB'(n - 1'b1);
    assign ia       = NB'(int'(a_reg) - 1);
    assign ib       = NB'(int'(b_reg) - 1);
    assign pw       = pred_reg[w_reg];
    assign rd_mult  = rdata_reg[DW - 1:RW];
    assign rd_res   = rdata_reg[RW - 1:0];
    assign mult_full = int'(rd_mult) >= MAX_MULT;
    assign enq_now  = (cmd.op == OP_BFS_CHK) && (rd_res != '0) && !visited_reg[v_reg];
    assign out_free = !out_valid_reg || result_ready;
    assign add_bad  = (a_reg == '0) || (b_reg == '0) || (int'(a_reg) > int'(n))
                   || (int'(b_reg) > int'(n)) || (a_reg == b_reg);

    always_comb
    begin
        status.mode        = mode_reg;
        status.item_valid  = item_valid;
        status.add_bad     = add_bad;
        status.mult_full   = mult_full;
        status.v_last      = (v_reg == last);
        status.q_empty     = (head_reg == tail_reg) && !enq_now;
        status.sink_seen   = visited_reg[last];
        status.pred_is_src = (pw == '0);
        status.clr_last    = &clr_idx_reg;
        status.rd_end      = send_reg;
        status.rd_cand     = (si_reg <= last) && (sj_reg <= last)
                          && !reach_reg[si_reg] && reach_reg[sj_reg];
        status.mult_nz     = (rd_mult != '0);
        status.out_free    = out_free;
    end

    // Row-major walk over the whole matrix, so the cursor keeps its place even if the
    // node count changes between a solve and the reads; pairs outside the live nodes
    // are skipped.
    always_comb
    begin
        si_next   = si_reg;
        sj_next   = sj_reg + 1'b1;
        send_next = 1'b0;
        if (sj_reg == WALK_LAST)
        begin
            sj_next = '0;
            if (si_reg == WALK_LAST)
            begin
                si_next   = si_reg;
                sj_next   = sj_reg;
                send_next = 1'b1;
            end
            else
            begin
                si_next = si_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        raddr = '0;
        waddr = '0;
        wdata = '0;
        wen   = 1'b0;
        case (cmd.op)
            OP_CLR:
            begin
                wen   = 1'b1;
                waddr = clr_idx_reg;
            end
            OP_ADD_RD: raddr = {ia, ib};
            OP_ADD_AB:
            begin
                wen   = !mult_full;
                waddr = {ia, ib};
                wdata = {rd_mult + 1'b1, rd_res + 1'b1};
                raddr = {ib, ia};
            end
            OP_ADD_BA:
            begin
                wen   = 1'b1;
                waddr = {ib, ia};
                wdata = {rd_mult + 1'b1, rd_res + 1'b1};
            end
            OP_BFS_RD: raddr = {u_reg, v_reg};
            OP_AUG_RD: raddr = {pw, w_reg};
            OP_AUG_FWD:
            begin
                wen   = 1'b1;
                waddr = {pw, w_reg};
                wdata = {rd_mult, rd_res - 1'b1};
                raddr = {w_reg, pw};
            end
            OP_AUG_REV:
            begin
                wen   = 1'b1;
                waddr = {w_reg, pw};
                wdata = {rd_mult, rd_res + 1'b1};
            end
            OP_RD_ISSUE: raddr = {sj_reg, si_reg};
            default:     raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wen) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            visited_reg   <= '0;
            reach_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            flow_reg      <= '0;
            cur_i_reg     <= '0;
            cur_j_reg     <= '0;
            cur_end_reg   <= 1'b0;
            send_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_RESP)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    reach_reg   <= '0;
                    flow_reg    <= '0;
                    cur_i_reg   <= '0;
                    cur_j_reg   <= '0;
                    cur_end_reg <= 1'b0;
                end
                OP_BFS_INIT:
                begin
                    visited_reg <= MAX_NODES'(1);
                    head_reg    <= '0;
                    tail_reg    <= (NB + 1)'(1);
                end
                OP_BFS_POP: head_reg <= head_reg + 1'b1;
                OP_BFS_CHK:
                begin
                    if (enq_now)
                    begin
                        visited_reg[v_reg] <= 1'b1;
                        if (int'(tail_reg) < MAX_NODES) tail_reg <= tail_reg + 1'b1;
                    end
                end
                OP_AUG_REV:
                begin
                    if (pw == '0 && flow_reg != '1) flow_reg <= flow_reg + 1'b1;
                end
                OP_FINISH:
                begin
                    reach_reg   <= visited_reg;
                    cur_i_reg   <= '0;
                    cur_j_reg   <= '0;
                    cur_end_reg <= 1'b0;
                end
                OP_RD_START: send_reg <= cur_end_reg;
                OP_RD_ADV:   send_reg <= send_next;
                OP_RD_HIT:
                begin
                    send_reg <= send_next;
                    if (rd_mult != '0)
                    begin
                        cur_i_reg   <= si_next;
                        cur_j_reg   <= sj_next;
                        cur_end_reg <= send_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                mode_reg     <= mode_t'(mode);
                a_reg        <= node_a;
                b_reg        <= node_b;
                res_kind_reg <= KIND_ACK;
                res_ign_reg  <= 1'b0;
                res_lo_reg   <= '0;
                res_hi_reg   <= '0;
            end
            OP_REFUSE: res_ign_reg <= 1'b1;
            OP_ADD_AB: if (mult_full) res_ign_reg <= 1'b1;
            OP_BFS_INIT: queue_reg[0] <= '0;
            OP_BFS_POP:
            begin
                u_reg <= queue_reg[head_reg[NB - 1:0]];
                v_reg <= '0;
            end
            OP_BFS_CHK:
            begin
                v_reg <= v_reg + 1'b1;
                if (enq_now)
                begin
                    pred_reg[v_reg] <= u_reg;
                    if (int'(tail_reg) < MAX_NODES) queue_reg[tail_reg[NB - 1:0]] <= v_reg;
                end
            end
            OP_AUG_START: w_reg <= last;
            OP_AUG_REV:   w_reg <= pw;
            OP_FINISH:    res_kind_reg <= KIND_FLOW;
            OP_RD_START:
            begin
                si_reg       <= cur_i_reg;
                sj_reg       <= cur_j_reg;
                res_kind_reg <= KIND_NONE;
            end
            OP_RD_ADV:
            begin
                si_reg <= si_next;
                sj_reg <= sj_next;
            end
            OP_RD_HIT:
            begin
                si_reg <= si_next;
                sj_reg <= sj_next;
                if (rd_mult != '0)
                begin
                    res_kind_reg <= KIND_CUT;
                    if (sj_reg < si_reg)
                    begin
                        res_lo_reg <= NODE_W'(int'(sj_reg) + 1);
                        res_hi_reg <= NODE_W'(int'(si_reg) + 1);
                    end
                    else
                    begin
                        res_lo_reg <= NODE_W'(int'(si_reg) + 1);
                        res_hi_reg <= NODE_W'(int'(sj_reg) + 1);
                    end
                end
            end
            OP_RESP:
            begin
                out_kind_reg <= res_kind_reg;
                out_flow_reg <= flow_reg;
                out_lo_reg   <= res_lo_reg;
                out_hi_reg   <= res_hi_reg;
                out_ign_reg  <= res_ign_reg;
            end
            default: ;
        endcase
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign flow_value   = out_flow_reg;
    assign edge_low     = out_lo_reg;
    assign edge_high    = out_hi_reg;
    assign ignored      = out_ign_reg;

endmodule

[sv/min_cut_edge_finder_core.sv]
// Add edge: decode, read the pair, write both directions, then respond; a pair refused at
// decode goes straight to the result, and a full pair writes nothing. Read: the walk visits
// every pair of the full matrix and fetches each candidate pair. Solve: a search reads the
// row of each dequeued node; each unit of flow adds a search and a read and two writes per
// path edge; clear sweeps 4**NB cells. One item at a time; the next item is taken while the
// previous result waits. After reset the matrix is swept to zero as in a clear, item_ready low.
module min_cut_edge_finder_core
    import mcef_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_MULT  = DEF_MAX_MULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW - 1:0] paddr,
    input  logic [APB_DW - 1:0] pwdata,
    output logic [APB_DW - 1:0] prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          mode,
    input  logic [NODE_W - 1:0] node_a,
    input  logic [NODE_W - 1:0] node_b,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [1:0]          kind,
    output logic [FLOW_W - 1:0] flow_value,
    output logic [NODE_W - 1:0] edge_low,
    output logic [NODE_W - 1:0] edge_high,
    output logic                ignored
);

    localparam int NW = $clog2(MAX_NODES + 1);

    logic [CFG_W - 1:0] node_count_reg;
    logic [NW - 1:0]    n_eff;
    logic               reg_sel;
    dp_cmd_t            cmd;
    dp_status_t         status;

    assign pready  = 1'b1;
    assign reg_sel = (int'(paddr[APB_AW - 1:2]) == REG_NODE_COUNT);
    assign prdata  = reg_sel ? APB_DW'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CFG_W'(16);
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            node_count_reg <= pwdata[CFG_W - 1:0];
        end
    end

    // The node count is clamped into the range the matrix supports.
    always_comb
    begin
        if (int'(node_count_reg) > MAX_NODES)
            n_eff = NW'(MAX_NODES);
        else if (node_count_reg < CFG_W'(2))
            n_eff = NW'(2);
        else
            n_eff = NW'(node_count_reg);
    end

    assign item_ready = cmd.take_item;

    mcef_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mcef_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_MULT  (MAX_MULT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .n            (n_eff),
        .item_valid   (item_valid),
        .mode         (mode),
        .node_a       (node_a),
        .node_b       (node_b),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .flow_value   (flow_value),
        .edge_low     (edge_low),
        .edge_high    (edge_high),
        .ignored      (ignored)
    );

endmodule

[sv/mcef_checker.sv]
module mcef_checker
    import mcef_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input logic [1:0]          kind,
    input logic [NODE_W - 1:0] edge_low,
    input logic [NODE_W - 1:0] edge_high,
    input logic                ignored
);

`include "min_cut_edge_finder_core_assert.svh"

    `MCEF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result beat dropped")
    `MCEF_ASSERT_NOW(a_cut_order, result_valid && kind == KIND_CUT, edge_low != 0 && edge_low < edge_high, "cut pair not ordered")
    `MCEF_ASSERT_NOW(a_no_pair, result_valid && kind != KIND_CUT, edge_low == 0 && edge_high == 0, "pair on non-cut beat")
    `MCEF_ASSERT_NOW(a_ignored_ack, result_valid && ignored, kind == KIND_ACK, "ignored set on non-ack beat")

endmodule

bind min_cut_edge_finder_core mcef_checker u_mcef_checker (.*);

[sim/tb_min_cut_edge_finder_core.sv]
`timescale 1ns / 1ps

module tb_min_cut_edge_finder_core;
    import mcef_pkg::*;

    localparam int NMAX = DEF_MAX_NODES;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] flow;
        logic [4:0] lo;
        logic [4:0] hi;
        logic       ign;
    } answer_t;

    typedef struct {
        mode_t      md;
        logic [4:0] a;
        logic [4:0] b;
        bit         typed;
        answer_t    ans;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW - 1:0] paddr;
    logic [APB_DW - 1:0] pwdata;
    logic [APB_DW - 1:0] prdata;
    logic                pready;
    logic                item_valid;
    logic                item_ready;
    logic [1:0]          mode;
    logic [NODE_W - 1:0] node_a;
    logic [NODE_W - 1:0] node_b;
    logic                result_valid;
    logic                result_ready;
    logic [1:0]          kind;
    logic [FLOW_W - 1:0] flow_value;
    logic [NODE_W - 1:0] edge_low;
    logic [NODE_W - 1:0] edge_high;
    logic                ignored;

    min_cut_edge_finder_core u_dut (.*);

    // Predictor state.
    int unsigned mult_m [NMAX][NMAX];
    int unsigned resid_m [NMAX][NMAX];
    int unsigned parent_of [NMAX];
    bit          seen [NMAX];
    bit          reach [NMAX];
    int unsigned flow_total;
    int unsigned cursor;
    logic [4:0]  node_cnt_reg;

    answer_t     pending_answers[$];
    int          fail_count;
    int          results_seen;
    int          cuts_seen;
    int          solves_sent;
    bit          hold_off;
    bit          stim_done;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned nodes_in_use();
        int unsigned n;
        n = int'(node_cnt_reg);
        if (n < 2) n = 2;
        if (n > NMAX) n = NMAX;
        return n;
    endfunction

    function automatic void wipe_graph();
        foreach (mult_m[i, j])
        begin
            mult_m[i][j] = 0;
            resid_m[i][j] = 0;
        end
        foreach (seen[i])
        begin
            seen[i] = 0;
            reach[i] = 0;
        end
        flow_total = 0;
        cursor = 0;
    endfunction

    function automatic bit bfs_reaches_sink(int unsigned n);
        int unsigned q[$];
        int unsigned u;
        int unsigned enq;
        foreach (seen[i]) seen[i] = 0;
        seen[0] = 1;
        q.insert(q.size(), 0);
        enq = 1;
        while (q.size() > 0)
        begin
            u = q.pop_front();
            for (int unsigned v = 0; v < n; v++)
            begin
                if (resid_m[u][v] == 0 || seen[v]) continue;
                seen[v] = 1;
                parent_of[v] = u;
                if (enq < NMAX)
                begin
                    q.insert(q.size(), v);
                    enq++;
                end
            end
        end
        return seen[n - 1];
    endfunction

    function automatic answer_t predict_answer(mode_t md, logic [4:0] a, logic [4:0] b);
        answer_t r;
        int unsigned n;
        int unsigned v;
        int unsigned u;
        int unsigned i;
        int unsigned j;
        n = nodes_in_use();
        r = '0;
        case (md)
            MODE_ADD:
            begin
                if (a == 0 || b == 0 || a > n || b > n || a == b)
                    r.ign = 1'b1;
                else if (mult_m[a - 1][b - 1] >= DEF_MAX_MULT)
                    r.ign = 1'b1;
                else
                begin
                    mult_m[a - 1][b - 1]++;
                    mult_m[b - 1][a - 1]++;
                    resid_m[a - 1][b - 1]++;
                    resid_m[b - 1][a - 1]++;
                end
                r.kind = KIND_ACK;
            end
            MODE_SOLVE:
            begin
                while (bfs_reaches_sink(n))
                begin
                    v = n - 1;
                    while (v != 0)
                    begin
                        u = parent_of[v];
                        resid_m[u][v]--;
                        resid_m[v][u]++;
                        v = u;
                    end
                    if (flow_total < 255) flow_total++;
                end
                void'(bfs_reaches_sink(n));
                foreach (reach[k]) reach[k] = (k < n) ? seen[k] : 1'b0;
                cursor = 0;
                r.kind = KIND_FLOW;
            end
            MODE_READ:
            begin
                r.kind = KIND_NONE;
                for (int unsigned p = cursor; p < NMAX * NMAX; p++)
                begin
                    i = p / NMAX;
                    j = p % NMAX;
                    if (i >= n || j >= n) continue;
                    if (reach[i] || !reach[j]) continue;
                    if (mult_m[j][i] == 0) continue;
                    r.kind = KIND_CUT;
                    r.lo = 5'((j < i ? j : i) + 1);
                    r.hi = 5'((j < i ? i : j) + 1);
                    cursor = p + 1;
                    break;
                end
            end
            default:
            begin
                wipe_graph();
                r.kind = KIND_ACK;
            end
        endcase
        r.flow = flow_total[7:0];
        return r;
    endfunction

    task automatic write_node_count(logic [4:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_NODE_COUNT);
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_cnt_reg = value;
    endtask

    // The expectation is queued at the accepting edge, so the predictor sees items in order.
    // Valid stays high into the next item when no idle cycles are drawn.
    task automatic send_item(mode_t md, logic [4:0] a, logic [4:0] b);
        int unsigned gap;
        gap = $urandom_range(0, 9);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= md;
        node_a     <= a;
        node_b     <= b;
        do @(posedge clk); while (!item_ready);
        pending_answers.insert(pending_answers.size(), predict_answer(md, a, b));
        if (md == MODE_SOLVE) solves_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int unsigned n;
        int unsigned r;
        n = nodes_in_use();
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_item(MODE_ADD, 5'($urandom_range(1, n)), 5'($urandom_range(1, n)));
            else if (r < 66)
                send_item(MODE_ADD, 5'($urandom), 5'($urandom));
            else if (r < 74)
                send_item(MODE_SOLVE, 5'($urandom), 5'($urandom));
            else if (r < 97)
                send_item(MODE_READ, 5'($urandom), 5'($urandom));
            else
                send_item(MODE_CLEAR, 5'($urandom), 5'($urandom));
        end
    endtask

    // Result side: a fresh random wait before each beat, with one long hold-off
    // requested by the stimulus.
    initial begin
        int unsigned wait_cycles;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (result_ready)
            begin
                if (result_valid) result_ready <= 1'b0;
            end
            else if (result_valid)
            begin
                wait_cycles = $urandom_range(0, 9);
                repeat (wait_cycles) @(posedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    initial begin
        answer_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                results_seen++;
                if (kind == KIND_CUT) cuts_seen++;
                if (pending_answers.size() == 0)
                begin
                    $error("unexpected result beat, kind %0d", kind);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_answers.pop_front();
                    if (kind !== exp_r.kind)
                    begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                        fail_count++;
                    end
                    if (flow_value !== exp_r.flow)
                    begin
                        $error("flow_value: expected %0d, got %0d", exp_r.flow, flow_value);
                        fail_count++;
                    end
                    if (edge_low !== exp_r.lo)
                    begin
                        $error("edge_low: expected %0d, got %0d", exp_r.lo, edge_low);
                        fail_count++;
                    end
                    if (edge_high !== exp_r.hi)
                    begin
                        $error("edge_high: expected %0d, got %0d", exp_r.hi, edge_high);
                        fail_count++;
                    end
                    if (ignored !== exp_r.ign)
                    begin
                        $error("ignored: expected %0d, got %0d", exp_r.ign, ignored);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        #200ms;
        $display("timeout with %0d results outstanding", pending_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        stim_row_t  rows[$];
        stim_row_t  row;
        answer_t    got;
        logic [4:0] counts[6];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        mode = MODE_ADD;
        node_a = '0;
        node_b = '0;
        hold_off = 1'b0;
        fail_count = 0;
        results_seen = 0;
        cuts_seen = 0;
        solves_sent = 0;
        node_cnt_reg = 5'd16;
        wipe_graph();
        foreach (parent_of[i]) parent_of[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows; typed answers are those obvious without running the flow.
        rows = '{
            '{MODE_READ,  5'd0,  5'd0,  1'b1, '{KIND_NONE, 8'd0, 5'd0, 5'd0, 1'b0}},
            '{MODE_ADD,   5'd3,  5'd3,  1'b1, '{KIND_ACK,  8'd0, 5'd0, 5'd0, 1'b1}},
            '{MODE_ADD,   5'd0,  5'd5,  1'b1, '{KIND_ACK,  8'd0, 5'd0, 5'd0, 1'b1}},
            '{MODE_ADD,   5'd17, 5'd2,  1'b1, '{KIND_ACK,  8'd0, 5'd0, 5'd0, 1'b1}},
            '{MODE_ADD,   5'd31, 5'd31, 1'b1, '{KIND_ACK,  8'd0, 5'd0, 5'd0, 1'b1}},
            '{MODE_ADD,   5'd1,  5'd16, 1'b1, '{KIND_ACK,  8'd0, 5'd0, 5'd0, 1'b0}},
            '{MODE_ADD,   5'd1,  5'd2,  1'b0, '0},
            '{MODE_ADD,   5'd2,  5'd16, 1'b0, '0},
            '{MODE_ADD,   5'd16, 5'd2,  1'b0, '0},
            '{MODE_ADD,   5'd1,  5'd3,  1'b0, '0},
            '{MODE_SOLVE, 5'd0,  5'd0,  1'b0, '0},
            '{MODE_READ,  5'd0,  5'd0,  1'b0, '0},
            '{MODE_READ,  5'd0,  5'd0,  1'b0, '0},
            '{MODE_READ,  5'd0,  5'd0,  1'b0, '0},
            '{MODE_READ,  5'd0,  5'd0,  1'b0, '0},
            '{MODE_ADD,   5'd3,  5'd16, 1'b0, '0},
            '{MODE_SOLVE, 5'd0,  5'd0,  1'b0, '0},
            '{MODE_READ,  5'd0,  5'd0,  1'b0, '0},
            '{MODE_CLEAR, 5'd0,  5'd0,  1'b1, '{KIND_ACK,  8'd0, 5'd0, 5'd0, 1'b0}},
            '{MODE_READ,  5'd0,  5'd0,  1'b1, '{KIND_NONE, 8'd0, 5'd0, 5'd0, 1'b0}},
            '{MODE_SOLVE, 5'd0,  5'd0,  1'b1, '{KIND_FLOW, 8'd0, 5'd0, 5'd0, 1'b0}}
        };
        foreach (rows[k])
        begin
            row = rows[k];
            send_item(row.md, row.a, row.b);
            got = pending_answers[pending_answers.size() - 1];
            if (row.typed && got !== row.ans)
            begin
                $error("directed row %0d: table disagrees with predictor", k);
                fail_count++;
            end
        end
        // Saturate one pair to the multiplicity ceiling, then one more is refused.
        for (int k = 0; k < DEF_MAX_MULT + 1; k++) send_item(MODE_ADD, 5'd1, 5'd16);
        send_item(MODE_SOLVE, 5'd0, 5'd0);
        repeat (3) send_item(MODE_READ, 5'd0, 5'd0);
        send_item(MODE_CLEAR, 5'd0, 5'd0);

        // Register settings: out-of-range low and high, extremes, and a mid value.
        counts = '{5'd0, 5'd2, 5'd31, 5'd5, 5'd1, 5'd16};
        foreach (counts[c])
        begin
            wait_drained();
            write_node_count(counts[c]);
            if (c == 2)
            begin
                hold_off = 1'b1;
                random_phase(40);
            end
            random_phase(140);
            send_item(MODE_SOLVE, 5'd0, 5'd0);
            repeat (6) send_item(MODE_READ, 5'd0, 5'd0);
            send_item(MODE_CLEAR, 5'd0, 5'd0);
        end

        wait_drained();
        $display("%0d results checked, %0d solves, %0d cut edges read out over six node counts",
                 results_seen, solves_sent, cuts_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
